/* rtl/linear_svm_decision_sum_unit_defines.svh */
// ----------------------------------------------------------------------------
// Linear SVM decision sum: assertion macros
// Shared same-cycle-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SVM_DECISION_SUM_UNIT_DEFINES_SVH
`define LINEAR_SVM_DECISION_SUM_UNIT_DEFINES_SVH

// same-cycle implication
`define LSVM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsvm assertion failed");

// next-cycle implication
`define LSVM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsvm assertion failed");

`endif

/* rtl/lsvm_pkg.sv */
// ----------------------------------------------------------------------------
// Linear SVM decision sum: package
// Word types, codes, sequencer states and control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lsvm_pkg;

   localparam int MAX_SV_DEFAULT = 64;
   localparam int ACC_W          = 48;
   localparam int CNT_W          = 7;

   localparam logic [CNT_W-1:0] SV_COUNT_RESET = 7'd64;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // request kinds
   localparam logic REQ_WEIGHT = 1'b0;
   localparam logic REQ_TERM   = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [5:0]        sv_index;
      logic signed [15:0] weight_value;
      logic signed [15:0] feature_value;
      logic signed [15:0] sv_value;
      logic              last;
   } req_word_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] decision_sum;
      logic                    saturated;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TMUL,
      ST_TACC,
      ST_RED,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic busy;
      logic acc_clr;   // zero acc entry at cnt
      logic acc_wr;    // write term sum
      logic red_rd;    // reduction read at cnt
      logic term_mul;  // multiplier on term operands
      logic done;      // final sum ready
   } ctl_type;

endpackage

`default_nettype wire

/* rtl/lsvm_mult.sv */
// ----------------------------------------------------------------------------
// Linear SVM decision sum: shared multiplier
// Registered 48 x 16 signed multiply, used for terms and the reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module lsvm_mult (
   input  wire logic               clock,
   input  wire logic signed [47:0] op_a,
   input  wire logic signed [15:0] op_b,
   output logic signed [63:0]      prod
);

   logic signed [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 64'(op_a) * 64'(op_b);
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

/* rtl/lsvm_seq.sv */
// ----------------------------------------------------------------------------
// Linear SVM decision sum: sequencer
// Steps the clearing sweep, term read-modify-write and the reduction sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module lsvm_seq #(
   parameter  int MAX_SV = lsvm_pkg::MAX_SV_DEFAULT,
   localparam int AW     = (MAX_SV > 1) ? $clog2(MAX_SV) : 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        term_go,
   input  wire logic        term_last,
   input  wire logic        pipe_busy,
   output lsvm_pkg::ctl_type ctl,
   output logic [AW-1:0]    cnt
);

   localparam logic [AW-1:0] CNT_LAST = AW'(MAX_SV - 1);

   lsvm_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic                last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsvm_pkg::ST_CLEAR;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      ctl      = '0;
      unique case (state_ff)
         lsvm_pkg::ST_CLEAR: begin
            ctl.busy    = 1'b1;
            ctl.acc_clr = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = lsvm_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lsvm_pkg::ST_IDLE: begin
            if (term_go) begin
               last_in  = term_last;
               state_in = lsvm_pkg::ST_TMUL;
            end
         end
         lsvm_pkg::ST_TMUL: begin
            ctl.busy     = 1'b1;
            ctl.term_mul = 1'b1;
            state_in     = lsvm_pkg::ST_TACC;
         end
         lsvm_pkg::ST_TACC: begin
            ctl.busy   = 1'b1;
            ctl.acc_wr = 1'b1;
            state_in   = last_ff ? lsvm_pkg::ST_RED : lsvm_pkg::ST_IDLE;
         end
         lsvm_pkg::ST_RED: begin
            ctl.busy    = 1'b1;
            ctl.acc_clr = 1'b1;
            ctl.red_rd  = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = lsvm_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lsvm_pkg::ST_DRAIN: begin
            ctl.busy = 1'b1;
            if (!pipe_busy) begin
               ctl.done = 1'b1;
               state_in = lsvm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsvm_pkg::ST_IDLE;
         end
      endcase
   end

   assign cnt = cnt_ff;

endmodule

`default_nettype wire

/* rtl/linear_svm_decision_sum_unit.sv */
// ----------------------------------------------------------------------------
// Linear SVM decision sum unit
// Per-vector dot-product accumulators reduced by weights to one saturated sum.
// ----------------------------------------------------------------------------
// Usage:
//   Request words are taken on start while busy is low. A weight word stores
//   one weight. A term word multiplies feature by component on the shared
//   multiplier and adds into that vector's accumulator.
//   A term with last set then sweeps all MAX_SV accumulator entries, one per
//   cycle through the same multiplier, summing entries below the csr count,
//   and zeroes each entry as it passes. The result word strobes on rsp_strobe
//   for one cycle once the sweep and the reduction pipeline have drained.
//   The receiver cannot stall; the result sits in an output register so a
//   new word may be taken in the strobe cycle.
//   After reset the block runs a clearing sweep over all MAX_SV entries of the
//   accumulator memory with busy high. The count register resets to 64 and is
//   written through csr_valid/csr_ready while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_svm_decision_sum_unit #(
   parameter int MAX_SV = lsvm_pkg::MAX_SV_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire lsvm_pkg::req_word_type req_data,
   output logic                       rsp_strobe,
   output lsvm_pkg::rsp_word_type     rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [6:0]            csr_data
);

`include "linear_svm_decision_sum_unit_defines.svh"

   localparam int AW   = (MAX_SV > 1) ? $clog2(MAX_SV) : 1;
   localparam int CMPW = (AW > 7) ? AW + 1 : 8;
   localparam int SUMW = 65 + AW;
   localparam int HIW  = SUMW - 62;

   lsvm_pkg::ctl_type ctl;
   logic [AW-1:0]     cnt;

   logic accept, term_go, term_req, wgt_we, idx_ok;

   logic [6:0]         csr_count_ff;

   logic signed [47:0] acc_mem_ff [MAX_SV];
   logic signed [15:0] wgt_mem_ff [MAX_SV];
   logic signed [47:0] acc_rd_ff;
   logic signed [15:0] wgt_rd_ff;

   logic signed [15:0] f_ff, s_ff;
   logic [AW-1:0]      idx_ff;
   logic               idx_ok_ff;

   logic               v1_ff, v2_ff, use1_ff;
   logic signed [SUMW-1:0] sum_ff;

   logic               rsp_strobe_ff;
   lsvm_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic               acc_we, acc_re;
   logic [AW-1:0]      acc_wa, acc_ra;
   logic signed [47:0] acc_wd;

   logic signed [47:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [63:0] mul_p;

   logic signed [48:0] tsum;
   logic signed [47:0] tsum_sat;
   logic [HIW-1:0]     sum_hi;

   assign accept   = start && !ctl.busy;
   assign idx_ok   = 32'(req_data.sv_index) < MAX_SV;
   assign term_req = start && (req_data.req_type == lsvm_pkg::REQ_TERM);
   assign term_go  = accept && (req_data.req_type == lsvm_pkg::REQ_TERM);
   assign wgt_we   = accept && (req_data.req_type == lsvm_pkg::REQ_WEIGHT) && idx_ok;

   // sequencer only looks at term_req while idle, where busy is low
   lsvm_seq #(.MAX_SV(MAX_SV)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .term_go   (term_req),
      .term_last (req_data.last),
      .pipe_busy (v1_ff || v2_ff),
      .ctl       (ctl),
      .cnt       (cnt)
   );

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= lsvm_pkg::SV_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         csr_count_ff <= csr_data;
      end
   end

   // term operand capture
   always_ff @(posedge clock) begin
      if (term_go) begin
         f_ff      <= req_data.feature_value;
         s_ff      <= req_data.sv_value;
         idx_ff    <= AW'(req_data.sv_index);
         idx_ok_ff <= idx_ok;
      end
   end

   // accumulator term update with saturation
   assign tsum     = 49'(acc_rd_ff) + 49'(signed'(mul_p[31:0]));
   assign tsum_sat = (tsum[48] != tsum[47]) ?
                     (tsum[48] ? lsvm_pkg::ACC_MIN : lsvm_pkg::ACC_MAX) : tsum[47:0];

   assign acc_we = ctl.acc_clr || (ctl.acc_wr && idx_ok_ff);
   assign acc_wa = ctl.acc_clr ? cnt : idx_ff;
   assign acc_wd = ctl.acc_clr ? '0 : tsum_sat;
   assign acc_re = term_go || ctl.red_rd;
   assign acc_ra = ctl.red_rd ? cnt : AW'(req_data.sv_index);

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem_ff[acc_wa] <= acc_wd;
      end
      if (acc_re) begin
         acc_rd_ff <= acc_mem_ff[acc_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem_ff[AW'(req_data.sv_index)] <= req_data.weight_value;
      end
      if (ctl.red_rd) begin
         wgt_rd_ff <= wgt_mem_ff[cnt];
      end
   end

   // shared multiplier
   assign mul_a = ctl.term_mul ? 48'(f_ff) : acc_rd_ff;
   assign mul_b = ctl.term_mul ? s_ff : (use1_ff ? wgt_rd_ff : '0);

   lsvm_mult u_mult (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   // reduction pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         use1_ff <= 1'b0;
         sum_ff  <= '0;
      end else begin
         v1_ff   <= ctl.red_rd;
         use1_ff <= ctl.red_rd && (CMPW'(cnt) < CMPW'(csr_count_ff));
         v2_ff   <= v1_ff;
         if (ctl.done) begin
            sum_ff <= '0;
         end else if (v2_ff) begin
            sum_ff <= sum_ff + SUMW'(mul_p);
         end
      end
   end

   // final shift by 15 and clamp to 48 bits
   assign sum_hi = sum_ff[SUMW-1:62];

   always_comb begin
      if ((&sum_hi) || !(|sum_hi)) begin
         rsp_data_in.decision_sum = sum_ff[62:15];
         rsp_data_in.saturated    = 1'b0;
      end else begin
         rsp_data_in.decision_sum = sum_ff[SUMW-1] ? lsvm_pkg::ACC_MIN : lsvm_pkg::ACC_MAX;
         rsp_data_in.saturated    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl.done;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.done) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign busy       = ctl.busy;
   assign csr_ready  = !ctl.busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `LSVM_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `LSVM_ASSERT_NXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `LSVM_ASSERT_NXT(a_term_busy, clock, reset, term_go, busy)
   `LSVM_ASSERT_IMP(a_done_drained, clock, reset, ctl.done, !v1_ff && !v2_ff)

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear SVM decision sum unit: testbench
// Drives weight and term words, predicts each decision sum from a local copy
// of the accumulators and weights, and checks every strobed result in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SV_SLOTS = lsvm_pkg::MAX_SV_DEFAULT;
   localparam int DRAIN_CYCLES = SV_SLOTS + 16;
   localparam longint SUM_MAX = (longint'(1) <<< 47) - 1;
   localparam longint SUM_MIN = -(longint'(1) <<< 47);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   lsvm_pkg::req_word_type req_data = '0;
   logic rsp_strobe;
   lsvm_pkg::rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [6:0] csr_data = lsvm_pkg::SV_COUNT_RESET;

   longint dot_acc [SV_SLOTS];
   logic signed [15:0] weight_mem [SV_SLOTS];
   bit weight_loaded [SV_SLOTS];
   logic [6:0] count_reg = lsvm_pkg::SV_COUNT_RESET;
   lsvm_pkg::rsp_word_type pending_sums [$];
   int failures = 0;
   int sums_checked = 0;
   int words_sent = 0;
   int idle_pct = 0;

   linear_svm_decision_sum_unit uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint clip48(input longint v, output bit hit);
      hit = 1'b1;
      if (v > SUM_MAX) return SUM_MAX;
      if (v < SUM_MIN) return SUM_MIN;
      hit = 1'b0;
      return v;
   endfunction

   function automatic int active_span();
      return (count_reg > SV_SLOTS) ? SV_SLOTS : int'(count_reg);
   endfunction

   function automatic logic signed [15:0] pick_q15();
      case ($urandom_range(7))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         3: return 16'($signed($urandom_range(16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic lsvm_pkg::req_word_type make_word(input logic kind, input int idx,
                                                        input int wv, input int fv,
                                                        input int sv, input logic fin);
      lsvm_pkg::req_word_type w;
      w.req_type = kind;
      w.sv_index = 6'(idx);
      w.weight_value = 16'(wv);
      w.feature_value = 16'(fv);
      w.sv_value = 16'(sv);
      w.last = fin;
      return w;
   endfunction

   function automatic lsvm_pkg::req_word_type random_word();
      lsvm_pkg::req_word_type w;
      int span;
      span = active_span();
      w.req_type = ($urandom_range(99) < 15) ? lsvm_pkg::REQ_WEIGHT : lsvm_pkg::REQ_TERM;
      if (span > 0 && $urandom_range(1))
         w.sv_index = 6'($urandom_range(span - 1));
      else
         w.sv_index = 6'($urandom);
      w.weight_value = pick_q15();
      w.feature_value = pick_q15();
      w.sv_value = pick_q15();
      w.last = ($urandom_range(7) == 0);
      return w;
   endfunction

   function automatic int next_gap();
      if (idle_pct != 0 && $urandom_range(99) < idle_pct)
         return $urandom_range(1, 6);
      return 0;
   endfunction

   // update the local copy of the block for one accepted word
   task automatic apply_word(input lsvm_pkg::req_word_type w);
      logic signed [79:0] total;
      longint prod;
      longint clipped;
      bit hit;
      lsvm_pkg::rsp_word_type r;
      if (w.req_type == lsvm_pkg::REQ_WEIGHT) begin
         weight_mem[w.sv_index] = w.weight_value;
         weight_loaded[w.sv_index] = 1'b1;
         return;
      end
      dot_acc[w.sv_index] = clip48(dot_acc[w.sv_index] +
         longint'(w.feature_value) * longint'(w.sv_value), hit);
      if (!w.last) return;
      total = '0;
      for (int i = 0; i < active_span(); i++) begin
         prod = dot_acc[i] * longint'(weight_mem[i]);
         total += prod;
      end
      clipped = clip48(longint'(total >>> 15), hit);
      r.decision_sum = clipped[47:0];
      r.saturated = hit;
      pending_sums.push_back(r);
      foreach (dot_acc[i]) dot_acc[i] = 0;
   endtask

   task automatic send_word(input lsvm_pkg::req_word_type w, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      apply_word(w);
      words_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_count(input logic [6:0] v);
      settle();
      while (busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_reg = v;
   endtask

   // a reduction may only read weights that were loaded
   task automatic ensure_weights();
      for (int i = 0; i < active_span(); i++)
         if (!weight_loaded[i])
            send_word(make_word(lsvm_pkg::REQ_WEIGHT, i, pick_q15(), 0, 0, 1'b0),
                      next_gap());
   endtask

   always @(posedge clock) begin : check_rsp
      lsvm_pkg::rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (pending_sums.size() == 0) begin
            $error("decision_sum: expected none, got %0d", $signed(rsp_data.decision_sum));
            failures++;
         end else begin
            want = pending_sums.pop_front();
            sums_checked++;
            if (rsp_data.decision_sum !== want.decision_sum) begin
               $error("decision_sum: expected %0d, got %0d",
                      $signed(want.decision_sum), $signed(rsp_data.decision_sum));
               failures++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %0b, got %0b", want.saturated,
                      rsp_data.saturated);
               failures++;
            end
         end
      end
   end

   // single vector; last on a weight word is ignored; extreme products
   task automatic test_single_vector();
      set_count(7'd1);
      send_word(make_word(lsvm_pkg::REQ_WEIGHT, 0, -32768, 0, 0, 1'b1), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 0, 0, 32767, 32767, 1'b0), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 0, 0, -32768, -32768, 1'b0), 1);
      send_word(make_word(lsvm_pkg::REQ_TERM, 9, 0, 12345, -321, 1'b1), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 0, 0, -1, 1, 1'b1), 2);
   endtask

   // count of zero sums nothing
   task automatic test_zero_count();
      set_count(7'd0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 0, 0, 32767, -32768, 1'b0), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 63, 0, -32768, 32767, 1'b1), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 5, 0, 0, 0, 1'b1), 0);
   endtask

   task automatic test_mixed_signs();
      set_count(7'd3);
      send_word(make_word(lsvm_pkg::REQ_WEIGHT, 1, 32767, 0, 0, 1'b0), 0);
      send_word(make_word(lsvm_pkg::REQ_WEIGHT, 2, 0, 0, 0, 1'b0), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 1, 0, -32768, 32767, 1'b0), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 2, 0, 32767, -32768, 1'b0), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 0, 0, -1, 1, 1'b0), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 63, 0, 32767, 32767, 1'b0), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 1, 0, -7, -3, 1'b1), 0);
      send_word(make_word(lsvm_pkg::REQ_WEIGHT, 0, 1, 0, 0, 1'b0), 0);
      send_word(make_word(lsvm_pkg::REQ_TERM, 0, 0, 32767, 32767, 1'b1), 3);
   endtask

   task automatic test_random_traffic(input int words, input logic [6:0] count,
                                      input int pct);
      lsvm_pkg::req_word_type w;
      set_count(count);
      idle_pct = pct;
      repeat (words) begin
         w = random_word();
         if (w.req_type == lsvm_pkg::REQ_TERM && w.last) ensure_weights();
         send_word(w, next_gap());
      end
      idle_pct = 0;
   endtask

   initial begin
      foreach (dot_acc[i]) begin
         dot_acc[i] = 0;
         weight_mem[i] = '0;
         weight_loaded[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_single_vector();
      test_zero_count();
      test_mixed_signs();
      test_random_traffic(250, 7'd64, 0);
      test_random_traffic(250, 7'd127, 55);
      test_random_traffic(250, 7'd1, 9);
      test_random_traffic(250, 7'd0, 0);
      test_random_traffic(250, 7'($urandom_range(2, 63)), 55);
      test_random_traffic(250, 7'd64, 9);
      test_random_traffic(250, 7'($urandom_range(2, 127)), 55);
      test_random_traffic(250, 7'd127, 0);
      settle();
      $display("Sent %0d request words and checked %0d decision sums,", words_sent,
               sums_checked);
      $display("with counts from 0 to 127, sender gaps, and extreme operand values.");
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
